/* sv/ihq_pkg.sv */
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared widths and sequencer states for the indexed min-heap queue.
// ----------------------------------------------------------------------------
package ihq_pkg;

    localparam int ITEM_W  = 8;   // item number field
    localparam int KEY_W   = 32;  // key field, signed Q16.16
    localparam int COUNT_W = 8;   // count field

    localparam logic MODE_SET    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_POS_RD  = 13'b0000000000010,
        ST_OLD_RD  = 13'b0000000000100,
        ST_RM_TOP  = 13'b0000000001000,
        ST_RM_LAST = 13'b0000000010000,
        ST_SU_CHK  = 13'b0000000100000,
        ST_SU_CMP  = 13'b0000001000000,
        ST_SD_CHK  = 13'b0000010000000,
        ST_SD_L    = 13'b0000100000000,
        ST_SD_R    = 13'b0001000000000,
        ST_SD_MOVE = 13'b0010000000000,
        ST_PUT     = 13'b0100000000000,
        ST_RESP    = 13'b1000000000000
    } state_t;

endpackage

/* sv/ihq_req_if.sv */
// ----------------------------------------------------------------------------
// ihq_req_if
// Request channel: mode, item number and key.
// ----------------------------------------------------------------------------
interface ihq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic [ihq_pkg::ITEM_W-1:0]        item;
    logic signed [ihq_pkg::KEY_W-1:0]  key;

    modport source (output valid, output mode, output item, output key, input ready);
    modport sink   (input valid, input mode, input item, input key, output ready);
endinterface

/* sv/ihq_rsp_if.sv */
// ----------------------------------------------------------------------------
// ihq_rsp_if
// Result channel: removed item, count and empty flag.
// ----------------------------------------------------------------------------
interface ihq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ihq_pkg::ITEM_W-1:0]   removed_item;
    logic [ihq_pkg::COUNT_W-1:0]  queue_count;
    logic                         queue_empty;

    modport source (output valid, output removed_item, output queue_count,
                    output queue_empty, input ready);
    modport sink   (input valid, input removed_item, input queue_count,
                    input queue_empty, output ready);
endinterface

/* sv/ihq_ram.sv */
// ----------------------------------------------------------------------------
// ihq_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/indexed_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap priority queue with a position map.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink)  : mode 0 sets the key of item 1..NI (insert if absent),
//                  mode 1 removes the item with the smallest key.
//   rsp  (source): one result per request: removed item (0 for mode 0 or an
//                  empty queue), item count after the request, empty flag.
// Timing:
//   One request at a time; req.ready is high only while the sequencer idles.
//   Each heap level going up reads the parent, then compares and moves;
//   going down it reads the left child, reads the right child if there is
//   one, then picks and moves. Levels run up to log2(NI); the single read
//   port of the heap RAM serialises these steps.
// Reset:
//   Queue empty at once: presence bits and count are flip-flops, the RAMs
//   need no clearing pass.
// Stall:
//   The result sits in an output register until rsp.ready; a request whose
//   result is done waits in the last state until that register is free.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue #(
    parameter int ITEMS    = 255,
    parameter int KEY_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    ihq_req_if.sink   req,
    ihq_rsp_if.source rsp
);

    // items above 255 can't be addressed by the 8-bit item field
    localparam int NI = (ITEMS < 255) ? ITEMS : 255;
    localparam int AW = $clog2(NI + 1);
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int HW = ihq_pkg::ITEM_W + KW;

    ihq_pkg::state_t state_reg, state_next;

    logic [AW-1:0]               occ_reg, occ_next;
    logic [NI:0]                 present_reg, present_next;
    logic [AW-1:0]               k_reg, k_next;
    logic [AW-1:0]               c_reg, c_next;
    logic [ihq_pkg::ITEM_W-1:0]  who_reg, who_next;
    logic signed [KW-1:0]        v_reg, v_next;
    logic [HW-1:0]               left_reg, left_next;
    logic [HW-1:0]               best_reg, best_next;
    logic [ihq_pkg::ITEM_W-1:0]  taken_reg, taken_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ihq_pkg::ITEM_W-1:0]  out_item_reg, out_item_next;
    logic [ihq_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic                        out_empty_reg, out_empty_next;

    // heap RAM: slot -> {item, key}; position RAM: item -> slot
    logic          heap_we;
    logic [AW-1:0] heap_waddr, heap_raddr;
    logic [HW-1:0] heap_wdata, heap_rdata;
    logic          pos_we;
    logic [AW-1:0] pos_waddr, pos_raddr;
    logic [AW-1:0] pos_wdata, pos_rdata;

    ihq_ram #(.WIDTH(HW), .DEPTH(NI + 1)) u_heap (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    ihq_ram #(.WIDTH(AW), .DEPTH(NI + 1)) u_pos (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    logic                       accept;
    logic [AW-1:0]              req_addr;
    logic                       item_ok;
    logic signed [KW-1:0]       req_key;
    logic [AW:0]                two_k;
    logic [ihq_pkg::ITEM_W-1:0] rd_item, best_item;
    logic signed [KW-1:0]       rd_key, left_key, best_key;

    assign req.ready = state_reg == ihq_pkg::ST_IDLE;
    assign accept    = req.valid && req.ready;
    assign req_addr  = req.item[AW-1:0];
    assign item_ok   = (req.item != '0) && (req.item <= ihq_pkg::ITEM_W'(NI));
    assign req_key   = req.key[KW-1:0];
    assign two_k     = {k_reg, 1'b0};

    assign rd_item   = heap_rdata[HW-1 -: ihq_pkg::ITEM_W];
    assign rd_key    = heap_rdata[KW-1:0];
    assign left_key  = left_reg[KW-1:0];
    assign best_item = best_reg[HW-1 -: ihq_pkg::ITEM_W];
    assign best_key  = best_reg[KW-1:0];

    assign rsp.valid        = out_valid_reg;
    assign rsp.removed_item = out_item_reg;
    assign rsp.queue_count  = out_count_reg;
    assign rsp.queue_empty  = out_empty_reg;

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        present_next   = present_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        who_next       = who_reg;
        v_next         = v_reg;
        left_next      = left_reg;
        best_next      = best_reg;
        taken_next     = taken_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_item_next  = out_item_reg;
        out_count_next = out_count_reg;
        out_empty_next = out_empty_reg;

        heap_we    = 1'b0;
        heap_waddr = k_reg;
        heap_wdata = best_reg;
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = best_reg[KW +: AW];
        pos_wdata  = k_reg;
        pos_raddr  = req_addr;

        case (state_reg)
            ihq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    taken_next = '0;
                    who_next   = req.item;
                    v_next     = req_key;
                    if (req.mode == ihq_pkg::MODE_SET)
                    begin
                        if (!item_ok)
                        begin
                            state_next = ihq_pkg::ST_RESP;
                        end
                        else if (!present_reg[req_addr])
                        begin
                            // append at the end, then sift up
                            present_next[req_addr] = 1'b1;
                            occ_next   = occ_reg + AW'(1);
                            k_next     = occ_reg + AW'(1);
                            state_next = ihq_pkg::ST_SU_CHK;
                        end
                        else
                        begin
                            state_next = ihq_pkg::ST_POS_RD;
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        state_next = ihq_pkg::ST_RESP;
                    end
                    else
                    begin
                        heap_raddr = AW'(1);
                        state_next = ihq_pkg::ST_RM_TOP;
                    end
                end
            end

            ihq_pkg::ST_POS_RD:
            begin
                k_next     = pos_rdata;
                heap_raddr = pos_rdata;
                state_next = ihq_pkg::ST_OLD_RD;
            end

            ihq_pkg::ST_OLD_RD:
            begin
                // key rose or stayed: down, fell: up
                if (rd_key <= v_reg)
                begin
                    state_next = ihq_pkg::ST_SD_CHK;
                end
                else
                begin
                    state_next = ihq_pkg::ST_SU_CHK;
                end
            end

            ihq_pkg::ST_RM_TOP:
            begin
                taken_next = rd_item;
                heap_raddr = occ_reg;
                state_next = ihq_pkg::ST_RM_LAST;
            end

            ihq_pkg::ST_RM_LAST:
            begin
                who_next   = rd_item;
                v_next     = rd_key;
                occ_next   = occ_reg - AW'(1);
                k_next     = AW'(1);
                present_next[taken_reg[AW-1:0]] = 1'b0;
                state_next = ihq_pkg::ST_SD_CHK;
            end

            ihq_pkg::ST_SU_CHK:
            begin
                heap_raddr = k_reg >> 1;
                if (k_reg > AW'(1))
                begin
                    state_next = ihq_pkg::ST_SU_CMP;
                end
                else
                begin
                    state_next = ihq_pkg::ST_PUT;
                end
            end

            ihq_pkg::ST_SU_CMP:
            begin
                // equal parent key is passed
                if (rd_key >= v_reg)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_item[AW-1:0];
                    k_next     = k_reg >> 1;
                    state_next = ihq_pkg::ST_SU_CHK;
                end
                else
                begin
                    state_next = ihq_pkg::ST_PUT;
                end
            end

            ihq_pkg::ST_SD_CHK:
            begin
                c_next     = two_k[AW-1:0];
                heap_raddr = two_k[AW-1:0];
                if ({1'b0, occ_reg} >= two_k)
                begin
                    state_next = ihq_pkg::ST_SD_L;
                end
                else
                begin
                    state_next = ihq_pkg::ST_PUT;
                end
            end

            ihq_pkg::ST_SD_L:
            begin
                left_next  = heap_rdata;
                best_next  = heap_rdata;
                heap_raddr = c_reg + AW'(1);
                if (c_reg < occ_reg)
                begin
                    state_next = ihq_pkg::ST_SD_R;
                end
                else
                begin
                    state_next = ihq_pkg::ST_SD_MOVE;
                end
            end

            ihq_pkg::ST_SD_R:
            begin
                // left child wins ties
                if (left_key > rd_key)
                begin
                    best_next = heap_rdata;
                    c_next    = c_reg + AW'(1);
                end
                state_next = ihq_pkg::ST_SD_MOVE;
            end

            ihq_pkg::ST_SD_MOVE:
            begin
                if (v_reg <= best_key)
                begin
                    state_next = ihq_pkg::ST_PUT;
                end
                else
                begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    pos_waddr  = best_item[AW-1:0];
                    k_next     = c_reg;
                    state_next = ihq_pkg::ST_SD_CHK;
                end
            end

            ihq_pkg::ST_PUT:
            begin
                heap_we    = 1'b1;
                heap_wdata = {who_reg, v_reg};
                pos_we     = 1'b1;
                pos_waddr  = who_reg[AW-1:0];
                state_next = ihq_pkg::ST_RESP;
            end

            ihq_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = taken_reg;
                    out_count_next = ihq_pkg::COUNT_W'(occ_reg);
                    out_empty_next = occ_reg == '0;
                    state_next     = ihq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ihq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ihq_pkg::ST_IDLE;
            occ_reg       <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        c_reg         <= c_next;
        who_reg       <= who_next;
        v_reg         <= v_next;
        left_reg      <= left_next;
        best_reg      <= best_next;
        taken_reg     <= taken_next;
        out_item_reg  <= out_item_next;
        out_count_reg <= out_count_next;
        out_empty_reg <= out_empty_next;
    end

endmodule
